// ----- hdl/vrc_pkg.sv -----
// Shared constants and controller/datapath interface types for the value rank block.
`default_nettype none
package vrc_pkg;

  localparam int MAX_COUNT    = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int VALUE_W      = 32;
  localparam int RANK_W       = 6;
  localparam int RANK_MAX     = 63;
  localparam int ADDR_W       = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int CNT_W        = $clog2(MAX_COUNT + 1);

  typedef struct packed {
    logic load;
    logic pivot_rd;
    logic scan_rd;
    logic emit;
  } vrc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic emit_last;
  } vrc_stat_t;

endpackage
`default_nettype wire

// ----- hdl/vrc_ctrl.sv -----
// Sequencer for load, pivot read, scan, drain and emit phases.
`default_nettype none
module vrc_ctrl
  import vrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      in_is_last,
  input  vrc_stat_t      stat,
  output vrc_cmd_t       cmd,
  output logic           busy
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PIV   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } vrc_state_t;

  vrc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_is_last) state_nxt = ST_PIV;
        end
      end
      ST_PIV: begin
        cmd.pivot_rd = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = stat.emit_last ? ST_IDLE : ST_PIV;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ----- hdl/vrc_datapath.sv -----
// Value store, counters, comparator and result registers.
`default_nettype none
module vrc_datapath
  import vrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  vrc_cmd_t                 cmd,
  input  wire logic [VALUE_W-1:0]  in_value,
  output vrc_stat_t                stat,
  output logic                     out_strobe,
  output logic [RANK_W-1:0]        out_rank,
  output logic                     out_last_rank,
  output logic                     out_overflowed
);

  logic [VALUE_W-1:0] mem [MAX_COUNT];
  logic [VALUE_W-1:0] rdata_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;

  logic [CNT_W-1:0]   count_r;
  logic               ovf_r;
  logic [CNT_W-1:0]   i_r;
  logic [CNT_W-1:0]   j_r;
  logic [CNT_W-1:0]   acc_r;
  logic [CNT_W-1:0]   emit_n;
  logic signed [VALUE_W-1:0] pivot_r;
  logic               piv_pend_r;
  logic               cmp_pend_r;
  logic               less;
  logic [RANK_W-1:0]  rank_sat;

  logic               out_strobe_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic               out_last_r;
  logic               out_ovf_r;

  assign rd_en   = cmd.pivot_rd | cmd.scan_rd;
  assign rd_addr = cmd.pivot_rd ? i_r[ADDR_W-1:0] : j_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && (32'(count_r) < MAX_COUNT)) begin
      mem[count_r[ADDR_W-1:0]] <= in_value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign emit_n = (32'(count_r) > RESULT_LIMIT) ? CNT_W'(RESULT_LIMIT) : count_r;
  assign stat.scan_last = (j_r == count_r - 1'b1);
  assign stat.emit_last = (i_r == emit_n - 1'b1);

  assign less     = $signed(rdata_r) < pivot_r;
  assign rank_sat = (32'(acc_r) > RANK_MAX) ? RANK_W'(RANK_MAX) : RANK_W'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      ovf_r        <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      acc_r        <= '0;
      piv_pend_r   <= 1'b0;
      cmp_pend_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      piv_pend_r   <= cmd.pivot_rd;
      cmp_pend_r   <= cmd.scan_rd;
      out_strobe_r <= cmd.emit;
      if (cmd.load) begin
        if (32'(count_r) < MAX_COUNT) begin
          count_r <= count_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.pivot_rd) begin
        j_r   <= '0;
        acc_r <= '0;
      end else begin
        if (cmd.scan_rd) j_r <= j_r + 1'b1;
        if (cmp_pend_r && less) acc_r <= acc_r + 1'b1;
      end
      if (cmd.emit) begin
        if (stat.emit_last) begin
          i_r     <= '0;
          count_r <= '0;
          ovf_r   <= 1'b0;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (piv_pend_r) pivot_r <= $signed(rdata_r);
    if (cmd.emit) begin
      out_rank_r <= rank_sat;
      out_last_r <= stat.emit_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_rank       = out_rank_r;
  assign out_last_rank  = out_last_r;
  assign out_overflowed = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.pivot_rd, cmd.scan_rd, cmd.emit}))
    else $error("more than one datapath command");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> (j_r < count_r))
    else $error("scan index past stored count");
  a_pivot_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pivot_rd |-> (count_r != '0) && (i_r < emit_n))
    else $error("pivot read with empty store or past emit count");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_strobe && !cmd.emit)
    else $error("result strobe not single cycle after emit");
`endif

endmodule
`default_nettype wire

// ----- hdl/value_rank_compression_top.sv -----
// Top level of the value rank block: controller plus datapath.
//
// Usage: drive in_value and in_is_last with start high; the item is taken at
// a clock edge where start is high and busy is low. Loading accepts one item
// per cycle. Values beyond the store capacity are dropped and flag the list.
// The item with in_is_last set closes the list and starts ranking; busy drops
// in the cycle that carries the last result.
// For a list of n stored values, min(n, 64) results follow in load order, each
// on out_rank/out_last_rank/out_overflowed for one cycle with out_strobe high.
// Each result is produced by one pivot read, n scan reads through the single
// read port of the value store, one compare drain and one emit step.
// The receiver cannot stall; results are simply presented and taken.
// Reset (rst_n low, synchronous) empties the store and clears the overflow flag;
// the value store itself is not cleared and needs no clearing pass.
`default_nettype none
module value_rank_compression_top
  import vrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic                in_is_last,
  output logic                     out_strobe,
  output logic [RANK_W-1:0]        out_rank,
  output logic                     out_last_rank,
  output logic                     out_overflowed
);

  vrc_cmd_t  cmd;
  vrc_stat_t stat;

  vrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_is_last (in_is_last),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  vrc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_value),
    .stat           (stat),
    .out_strobe     (out_strobe),
    .out_rank       (out_rank),
    .out_last_rank  (out_last_rank),
    .out_overflowed (out_overflowed)
  );

endmodule
`default_nettype wire
